/* hw/rtl/sasm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sasm_pkg;
   localparam int unsigned CORDIC_STEPS = 16;
   localparam int unsigned SHIFT_BITS = 4;
   localparam int unsigned LEN_BITS = 4;
   localparam int unsigned REF_BITS = 16;
   localparam int unsigned ANGLE_BITS = 16;
   localparam logic [23:0] RIGHT_ANGLE_Q16 = 24'd5898240;

   typedef logic [63:0] word_type;

   typedef struct packed {
      logic start;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] z;
   } angle_req_type;

   typedef struct packed {
      logic done;
      logic [ANGLE_BITS-1:0] angle;
   } angle_rsp_type;

   function automatic logic [23:0] atan_deg(input logic [3:0] i);
      logic [23:0] v;
      begin
         unique case (i)
            4'd0: v = 24'd2949120;
            4'd1: v = 24'd1740967;
            4'd2: v = 24'd919879;
            4'd3: v = 24'd466945;
            4'd4: v = 24'd234379;
            4'd5: v = 24'd117304;
            4'd6: v = 24'd58666;
            4'd7: v = 24'd29335;
            4'd8: v = 24'd14668;
            4'd9: v = 24'd7334;
            4'd10: v = 24'd3667;
            4'd11: v = 24'd1833;
            4'd12: v = 24'd917;
            4'd13: v = 24'd458;
            4'd14: v = 24'd229;
            default: v = 24'd115;
         endcase
         return v;
      end
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/sasm_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bit-pair restoring square root of a 64-bit value, one bit pair per cycle.
module sasm_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   output logic             done,
   output logic [31:0]      root
);
   logic [63:0] v_ff, v_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] b_ff, b_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      v_in = v_ff;
      r_in = r_ff;
      b_in = b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in = value;
         r_in = '0;
         b_in = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= r_ff + b_ff) begin
            v_in = v_ff - (r_ff + b_ff);
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule
`default_nettype wire

/* hw/rtl/sasm_angle.sv */
`timescale 1ns / 1ps
`default_nettype none
// Spectral angle from dot product and energies, one step per cycle except while waiting on the square root unit.
module sasm_angle (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sasm_pkg::angle_req_type req,
   output sasm_pkg::angle_rsp_type      rsp
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM, ST_SQY, ST_SQZ, ST_MUL, ST_DIV, ST_SIN_SQ, ST_SIN,
      ST_CORDIC, ST_DONE
   } state_type;

   state_type   state_ff;
   logic [63:0] x_ff, y_ff, z_ff;
   logic [6:0]  k_ff;
   logic [31:0] ry_ff, rz_ff;
   logic [63:0] d_ff, r_ff;
   logic [16:0] c_ff;
   logic [4:0]  cnt_ff;
   logic signed [20:0] cx_ff, cy_ff;
   logic signed [25:0] acc_ff;
   logic [15:0] angle_ff;
   logic        done_ff;
   logic        sq_start;
   logic [63:0] sq_value;
   logic        sq_done;
   logic [31:0] sq_root;
   logic [63:0] r_sh;
   logic signed [20:0] sx, sy;
   logic signed [25:0] acc_c;

   sasm_isqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .value(sq_value),
      .done(sq_done), .root(sq_root)
   );

   assign sq_start = (state_ff == ST_NORM && y_ff[63:60] != 4'd0 && z_ff[63:60] != 4'd0)
      || (state_ff == ST_SQY && sq_done) || (state_ff == ST_SIN_SQ);
   assign sq_value = (state_ff == ST_NORM) ? y_ff :
      (state_ff == ST_SQY) ? z_ff : (64'h1_0000_0000 - {30'd0, c_ff} * {30'd0, c_ff});
   assign r_sh = {r_ff[62:0], 1'b0};
   assign sx = cx_ff >>> cnt_ff[3:0];
   assign sy = (cy_ff < 0) ? -((-cy_ff) >>> cnt_ff[3:0]) : (cy_ff >>> cnt_ff[3:0]);
   always_comb begin
      if (acc_ff < 0) acc_c = '0;
      else if (acc_ff > $signed({2'b0, sasm_pkg::RIGHT_ANGLE_Q16})) acc_c = $signed({2'b0,
         sasm_pkg::RIGHT_ANGLE_Q16});
      else acc_c = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req.start) begin
                  x_ff <= req.x;
                  y_ff <= req.y;
                  z_ff <= req.z;
                  k_ff <= '0;
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               if (y_ff[63:60] == 4'd0) begin
                  y_ff <= y_ff << 2;
                  k_ff <= k_ff + 7'd1;
               end
               if (z_ff[63:60] == 4'd0) begin
                  z_ff <= z_ff << 2;
                  k_ff <= k_ff + 7'd1 + {6'd0, y_ff[63:60] == 4'd0};
               end
               if (y_ff[63:60] != 4'd0 && z_ff[63:60] != 4'd0) state_ff <= ST_SQY;
            end
            ST_SQY: begin
               if (sq_done) begin
                  ry_ff <= sq_root;
                  state_ff <= ST_SQZ;
               end
            end
            ST_SQZ: begin
               if (sq_done) begin
                  rz_ff <= sq_root;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               d_ff <= {32'd0, ry_ff} * {32'd0, rz_ff};
               r_ff <= x_ff << k_ff[5:0];
               c_ff <= '0;
               cnt_ff <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == 5'd0 && r_ff >= d_ff) begin
                  c_ff <= 17'h10000;
                  state_ff <= ST_SIN_SQ;
               end else begin
                  if (r_sh >= d_ff) begin
                     r_ff <= r_sh - d_ff;
                     c_ff <= {c_ff[15:0], 1'b1};
                  end else begin
                     r_ff <= r_sh;
                     c_ff <= {c_ff[15:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 5'd1;
                  if (cnt_ff == 5'd15) state_ff <= ST_SIN_SQ;
               end
            end
            ST_SIN_SQ: state_ff <= ST_SIN;
            ST_SIN: begin
               if (sq_done) begin
                  cx_ff <= $signed({4'd0, c_ff});
                  cy_ff <= $signed({4'd0, sq_root[16:0]});
                  acc_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               if (cnt_ff == 5'd16 || cy_ff == 0) begin
                  angle_ff <= 16'((26'(acc_c) + 26'd128) >> 8);
                  done_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  if (cy_ff > 0) begin
                     cx_ff <= cx_ff + sy;
                     cy_ff <= cy_ff - sx;
                     acc_ff <= acc_ff + $signed({2'b0,
                        sasm_pkg::atan_deg(cnt_ff[3:0])});
                  end else begin
                     cx_ff <= cx_ff - sy;
                     cy_ff <= cy_ff + sx;
                     acc_ff <= acc_ff - $signed({2'b0,
                        sasm_pkg::atan_deg(cnt_ff[3:0])});
                  end
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.angle = angle_ff;

   assert property (@(posedge clock) disable iff (reset) rsp.done |-> angle_ff <= 16'd23040)
      else $error("angle above ninety degrees");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CORDIC |-> cnt_ff <= 5'd16)
      else $error("cordic step count overrun");
   assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> state_ff == ST_IDLE)
      else $error("angle unit did not return to idle");
endmodule
`default_nettype wire

/* hw/rtl/spectral_angle_shift_matcher_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Loads one envelope position per transfer, one per cycle; the transfer with req_last
// starts the match and req_ready stays low until the last result has gone out. The
// envelope energy is summed first. Each shift then runs a multiply-accumulate over
// envelope_length positions and, unless its window is empty, one pass of the angle
// unit: normalizing the energies, three square roots, up to 16 division steps and up to
// 16 CORDIC steps. Results then stream one per cycle while rsp_ready is high, and the
// block returns to loading once the last result has been taken.
module spectral_angle_shift_matcher_top #(
   parameter int unsigned REF_LEN = 15,
   parameter int unsigned INTENSITY_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [23:0] req_intensity,
   input  wire logic [15:0] req_reference,
   input  wire logic [3:0]  req_envelope_length,
   input  wire logic [3:0]  req_shift_limit,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_shifted_reference,
   output logic [15:0]      rsp_best_angle,
   output logic [3:0]       rsp_best_shift,
   output logic             rsp_degenerate,
   output logic             rsp_last_result
);
   localparam int unsigned IB = (INTENSITY_BITS < 24) ? INTENSITY_BITS : 24;
   localparam int unsigned ISH = (INTENSITY_BITS > 24) ? INTENSITY_BITS - 24 : 0;
   localparam int unsigned CB = $clog2(REF_LEN + 1);
   localparam int unsigned AB = $clog2(REF_LEN);
   typedef enum logic [2:0] {
      ST_LOAD, ST_ZSUM, ST_XYSUM, ST_ANGLE, ST_WAIT, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [23:0] int_mem [REF_LEN];
   logic [15:0] ref_mem [REF_LEN];
   logic [CB-1:0] count_ff, n_ff;
   logic [3:0]  len_ff, lim_ff, shift_ff, j_ff, best_shift_ff;
   logic [63:0] x_ff, y_ff, z_ff;
   logic [15:0] best_ff;
   logic        degen_ff;
   logic [23:0] iv_ff;
   logic [15:0] rv_ff;
   logic        mac_ff;
   logic [4:0]  ridx;
   logic [4:0]  oidx;
   sasm_pkg::angle_req_type areq;
   sasm_pkg::angle_rsp_type arsp;

   assign ridx = 5'(shift_ff) + 5'(j_ff);
   assign oidx = 5'(j_ff) + 5'(best_shift_ff);

   sasm_angle u_angle (.clock(clock), .reset(reset), .req(areq), .rsp(arsp));
   assign areq.start = (state_ff == ST_ANGLE);
   assign areq.x = x_ff;
   assign areq.y = y_ff;
   assign areq.z = z_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && 32'(count_ff) < REF_LEN) begin
         int_mem[AB'(count_ff)] <= (req_intensity & 24'((64'd1 << IB) - 1)) >> ISH;
         ref_mem[AB'(count_ff)] <= req_reference;
      end
      iv_ff <= (32'(j_ff) < 32'(n_ff)) ? int_mem[AB'(j_ff)] : 24'd0;
      rv_ff <= (32'(ridx) < 32'(n_ff)) ? ref_mem[AB'(ridx)] : 16'd0;
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         len_ff <= '0;
         lim_ff <= '0;
         best_ff <= '0;
         best_shift_ff <= '0;
         degen_ff <= 1'b0;
         mac_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         mac_ff <= (state_ff == ST_ZSUM || state_ff == ST_XYSUM) && j_ff != len_ff;
         unique case (state_ff)
            ST_LOAD: begin
               if (req_valid) begin
                  if (count_ff == '0) begin
                     len_ff <= req_envelope_length;
                     lim_ff <= req_shift_limit;
                  end
                  if (32'(count_ff) < REF_LEN) count_ff <= count_ff + 1'b1;
                  if (req_last) begin
                     n_ff <= (32'(count_ff) < REF_LEN) ? count_ff + 1'b1 : count_ff;
                     count_ff <= '0;
                     j_ff <= '0;
                     z_ff <= '0;
                     degen_ff <= 1'b0;
                     state_ff <= ST_ZSUM;
                  end
               end
            end
            ST_ZSUM: begin
               if (j_ff == len_ff && !mac_ff) begin
                  j_ff <= '0;
                  shift_ff <= '0;
                  x_ff <= '0;
                  y_ff <= '0;
                  state_ff <= ST_XYSUM;
               end else begin
                  if (mac_ff) z_ff <= z_ff + {40'd0, iv_ff} * {40'd0, iv_ff};
                  if (j_ff != len_ff) j_ff <= j_ff + 4'd1;
               end
            end
            ST_XYSUM: begin
               if (j_ff == len_ff && !mac_ff) begin
                  j_ff <= '0;
                  if (y_ff == '0 || z_ff == '0) begin
                     if (shift_ff == '0) begin
                        best_ff <= '0;
                        best_shift_ff <= '0;
                        degen_ff <= 1'b1;
                        state_ff <= ST_OUT;
                     end else if (shift_ff == lim_ff) begin
                        state_ff <= ST_OUT;
                     end else begin
                        shift_ff <= shift_ff + 4'd1;
                     end
                  end else begin
                     state_ff <= ST_ANGLE;
                  end
               end else begin
                  if (mac_ff) begin
                     x_ff <= x_ff + {40'd0, iv_ff} * {48'd0, rv_ff};
                     y_ff <= y_ff + {48'd0, rv_ff} * {48'd0, rv_ff};
                  end
                  if (j_ff != len_ff) j_ff <= j_ff + 4'd1;
               end
            end
            ST_ANGLE: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (arsp.done) begin
                  if (shift_ff == '0 || arsp.angle < best_ff) begin
                     best_ff <= arsp.angle;
                     best_shift_ff <= shift_ff;
                  end
                  x_ff <= '0;
                  y_ff <= '0;
                  if (shift_ff == lim_ff) state_ff <= ST_OUT;
                  else begin
                     shift_ff <= shift_ff + 4'd1;
                     state_ff <= ST_XYSUM;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_valid || rsp_ready) begin
                  if (j_ff == len_ff) begin
                     rsp_valid <= 1'b0;
                     state_ff <= ST_LOAD;
                  end else begin
                     rsp_valid <= 1'b1;
                     rsp_shifted_reference <= (32'(oidx) < 32'(n_ff)) ?
                        ref_mem[AB'(oidx)] : 16'd0;
                     rsp_best_angle <= best_ff;
                     rsp_best_shift <= best_shift_ff;
                     rsp_degenerate <= degen_ff;
                     rsp_last_result <= (j_ff + 4'd1 == len_ff);
                     j_ff <= j_ff + 4'd1;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_LOAD);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT)
      else $error("result shown outside output phase");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_best_angle == 16'd0 && rsp_best_shift == 4'd0)
      else $error("degenerate result carries an angle");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> !req_ready)
      else $error("input taken during computation");
endmodule
`default_nettype wire
